// ----- rtl/core/sliding_histogram_median_filter_core_macros.svh -----
// Assertion macros for the sliding histogram median filter
`ifndef SLIDING_HISTOGRAM_MEDIAN_FILTER_CORE_MACROS_SVH
`define SLIDING_HISTOGRAM_MEDIAN_FILTER_CORE_MACROS_SVH

// clocked property, disabled while reset is asserted
`define SHMF_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("shmf assertion failed");

// condition that must never be seen
`define SHMF_ASSERT_NEVER(lbl, clk, rstn, cond) \
  `SHMF_ASSERT(lbl, clk, rstn, !(cond))

`endif

// ----- rtl/core/shmf_pkg.sv -----
// Shared types and constants of the sliding histogram median filter
`timescale 1ns / 1ps
package shmf_pkg;

  localparam int CFG_DW     = 11;
  localparam int CFG_IW     = 2;
  localparam int PIX_W      = 8;
  localparam int BINS       = 256;
  localparam int BIN_AW     = $clog2(BINS);
  localparam int CNT_W      = 8;
  localparam int SUM_W      = 16;
  localparam int ROW_W      = 11;
  localparam int MAX_HEIGHT = 1024;

  localparam logic [CFG_DW-1:0] W_RST = 11'd640;
  localparam logic [CFG_DW-1:0] H_RST = 11'd480;
  localparam logic [2:0]        R_RST = 3'd1;

  localparam logic              OP_PIXEL = 1'b0;
  localparam logic [PIX_W-1:0]  MED_NONE = 8'd255;
  localparam logic [BIN_AW-1:0] BIN_LAST = 8'd255;

  typedef enum logic [CFG_IW-1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_RADIUS = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic idle;
    logic take;
    logic eval;
    logic prep;
    logic addr;
    logic rd_line;
    logic rd_hist;
    logic wr_hist;
    logic scan;
    logic emit;
    logic adv;
  } shmf_cmd_t;

  typedef struct packed {
    logic kind_ok;
    logic has_out;
    logic job_last;
    logic scan_done;
    logic ox_last;
    logic out_free;
  } shmf_sts_t;

endpackage

// ----- rtl/core/shmf_ram.sv -----
// Generic single write port RAM with registered read
`timescale 1ns / 1ps
module shmf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/shmf_ctrl.sv -----
// Sequencing state machine of the median filter
`timescale 1ns / 1ps
module shmf_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  output logic                cfg_ready_o,
  input  shmf_pkg::shmf_sts_t sts_i,
  output shmf_pkg::shmf_cmd_t cmd_o
);
  import shmf_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE = 10'b00_0000_0001,
    S_EVAL = 10'b00_0000_0010,
    S_PREP = 10'b00_0000_0100,
    S_ADDR = 10'b00_0000_1000,
    S_RDLN = 10'b00_0001_0000,
    S_RDHS = 10'b00_0010_0000,
    S_WRHS = 10'b00_0100_0000,
    S_SCAN = 10'b00_1000_0000,
    S_EMIT = 10'b01_0000_0000,
    S_ADV  = 10'b10_0000_0000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        cmd_o.idle = 1'b1;
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          state_d    = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd_o.eval = 1'b1;
        if (!sts_i.kind_ok) begin
          state_d = S_IDLE;
        end else if (sts_i.has_out) begin
          state_d = S_PREP;
        end else begin
          state_d = S_ADV;
        end
      end
      S_PREP: begin
        cmd_o.prep = 1'b1;
        state_d    = S_ADDR;
      end
      S_ADDR: begin
        cmd_o.addr = 1'b1;
        state_d    = S_RDLN;
      end
      S_RDLN: begin
        cmd_o.rd_line = 1'b1;
        state_d       = S_RDHS;
      end
      S_RDHS: begin
        cmd_o.rd_hist = 1'b1;
        state_d       = S_WRHS;
      end
      S_WRHS: begin
        cmd_o.wr_hist = 1'b1;
        state_d       = sts_i.job_last ? S_SCAN : S_ADDR;
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.scan_done) begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = sts_i.ox_last ? S_ADV : S_PREP;
        end
      end
      S_ADV: begin
        cmd_o.adv = 1'b1;
        state_d   = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign cfg_ready_o = (state_q == S_IDLE);

endmodule

// ----- rtl/core/shmf_datapath.sv -----
// Line stores, histogram, counters and median scan of the filter
`timescale 1ns / 1ps
module shmf_datapath #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_RADIUS = 7
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  shmf_pkg::shmf_cmd_t             cmd_i,
  output shmf_pkg::shmf_sts_t             sts_o,
  input  logic                            op_i,
  input  logic [shmf_pkg::PIX_W-1:0]      pixel_i,
  input  logic                            cfg_valid_i,
  input  logic [shmf_pkg::CFG_IW-1:0]     cfg_index_i,
  input  logic [shmf_pkg::CFG_DW-1:0]     cfg_data_i,
  input  logic                            out_stall_i,
  output logic                            out_valid_o,
  output logic [shmf_pkg::PIX_W-1:0]      median_o,
  output logic                            last_of_run_o,
  output logic                            end_of_frame_o
);
  import shmf_pkg::*;

  localparam int RING   = 2 * MAX_RADIUS + 1;
  localparam int SLOT_W = $clog2(RING);
  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int WW     = $clog2(MAX_WIDTH + 1);
  localparam int RAD_W  = $clog2(MAX_RADIUS + 1);
  localparam int K_W    = RAD_W + 1;
  localparam int POS_W  = 2 * K_W;
  localparam int LA_W   = $clog2(RING * MAX_WIDTH);
  localparam int SC_W   = WW + 2;
  localparam int SR_W   = ROW_W + 2;

  // configuration and effective values
  logic [CFG_DW-1:0] width_q, height_q;
  logic [2:0]        radius_q;
  logic [WW-1:0]     eff_w, w_m1;
  logic [ROW_W-1:0]  eff_h, h_m1;
  logic [RAD_W-1:0]  eff_r;
  logic [SLOT_W-1:0] two_r;
  logic              cfg_we, cfg_hit;

  // position state
  logic [WW-1:0]     in_col_q, out_col_q, ox_q;
  logic [ROW_W-1:0]  in_row_q;
  logic [SLOT_W-1:0] in_slot_q;
  logic signed [WW:0] lim_q;
  logic              had_out_q;

  // item and column-update state
  logic              op_q;
  logic [PIX_W-1:0]  pix_q;
  logic [SLOT_W-1:0] j_q, ky_q, jlast_q;
  logic              rebuild_q, sub_q;
  logic [COL_W-1:0]  col_q, col_d;
  logic [SLOT_W-1:0] slot_q, slot_d;
  logic [BIN_AW-1:0] v_q;
  logic [BINS-1:0]   hist_vld_q;
  logic              hv_q;

  // scan state
  logic [BIN_AW:0]   scan_idx_q;
  logic [BIN_AW-1:0] data_idx_q;
  logic              rd_vld_q, done_q;
  logic [SUM_W-1:0]  sum_q, acc;
  logic [POS_W-1:0]  pos_q;
  logic [PIX_W-1:0]  med_q;
  logic              found;

  // output register
  logic              out_vld_q, last_q, eof_q;
  logic [PIX_W-1:0]  median_q;

  // combinational
  logic               is_real, kind_ok, row_end, has_out, ox_last, eof_c, job_last;
  logic signed [WW:0] lim_c;
  logic signed [SC_W-1:0] col_raw, ox_s, r_s, j_s;
  logic signed [SR_W-1:0] py_raw;
  logic [ROW_W-1:0]  py, oy;
  logic [SLOT_W-1:0] row_gap;
  logic [K_W-1:0]    k_c;
  logic [POS_W-1:0]  kk_c;
  logic [LA_W-1:0]   lw_addr, lr_addr;
  logic              line_we;
  logic [PIX_W-1:0]  line_rdata;
  logic [BIN_AW-1:0] hist_raddr;
  logic [CNT_W-1:0]  hist_rdata, cnt, hist_wdata;

  always_comb begin
    if (width_q == '0) begin
      eff_w = WW'(1);
    end else if (int'(width_q) > MAX_WIDTH) begin
      eff_w = WW'(MAX_WIDTH);
    end else begin
      eff_w = WW'(width_q);
    end
    if (height_q == '0) begin
      eff_h = ROW_W'(1);
    end else if (int'(height_q) > MAX_HEIGHT) begin
      eff_h = ROW_W'(MAX_HEIGHT);
    end else begin
      eff_h = ROW_W'(height_q);
    end
    if (radius_q == '0) begin
      eff_r = RAD_W'(1);
    end else if (int'(radius_q) > MAX_RADIUS) begin
      eff_r = RAD_W'(MAX_RADIUS);
    end else begin
      eff_r = RAD_W'(radius_q);
    end
  end

  assign w_m1  = eff_w - WW'(1);
  assign h_m1  = eff_h - ROW_W'(1);
  assign two_r = SLOT_W'({eff_r, 1'b0});

  assign cfg_we  = cfg_valid_i && cmd_i.idle;
  assign cfg_hit = cfg_we && ((cfg_index_i == REG_WIDTH) || (cfg_index_i == REG_HEIGHT) ||
                              (cfg_index_i == REG_RADIUS));

  // item classification and output span
  assign is_real = in_row_q < eff_h;
  assign kind_ok = (op_q == OP_PIXEL) == is_real;
  assign row_end = in_col_q == w_m1;
  assign lim_c   = row_end ? $signed({1'b0, w_m1})
                           : $signed({1'b0, in_col_q}) - $signed((WW + 1)'(eff_r));
  assign has_out = (in_row_q >= ROW_W'(eff_r)) && (lim_c >= $signed({1'b0, out_col_q}));

  // window column and ring slot of the next line read
  always_comb begin
    ox_s = $signed(SC_W'(ox_q));
    r_s  = $signed(SC_W'(eff_r));
    j_s  = $signed(SC_W'(j_q));
    if (rebuild_q) begin
      col_raw = j_s - r_s;
    end else if (j_q == '0) begin
      col_raw = ox_s - r_s - $signed(SC_W'(1));
    end else begin
      col_raw = ox_s + r_s;
    end
    if (col_raw[SC_W-1]) begin
      col_d = '0;
    end else if (col_raw > $signed(SC_W'(w_m1))) begin
      col_d = COL_W'(w_m1);
    end else begin
      col_d = COL_W'(col_raw);
    end

    py_raw = $signed(SR_W'(in_row_q)) - $signed(SR_W'(two_r)) + $signed(SR_W'(ky_q));
    if (py_raw[SR_W-1]) begin
      py = '0;
    end else if (py_raw > $signed(SR_W'(h_m1))) begin
      py = h_m1;
    end else begin
      py = ROW_W'(py_raw);
    end
    row_gap = SLOT_W'(in_row_q - py);
    if (in_slot_q < row_gap) begin
      slot_d = SLOT_W'((SLOT_W + 1)'(in_slot_q) + (SLOT_W + 1)'(RING) - (SLOT_W + 1)'(row_gap));
    end else begin
      slot_d = in_slot_q - row_gap;
    end
  end

  assign lw_addr = LA_W'(in_slot_q) * LA_W'(MAX_WIDTH) + LA_W'(in_col_q);
  assign lr_addr = LA_W'(slot_q) * LA_W'(MAX_WIDTH) + LA_W'(col_q);
  assign line_we = cmd_i.eval && kind_ok && is_real;

  assign hist_raddr = cmd_i.rd_hist ? line_rdata : scan_idx_q[BIN_AW-1:0];
  assign cnt        = hv_q ? hist_rdata : '0;
  assign hist_wdata = sub_q ? cnt - CNT_W'(1) : cnt + CNT_W'(1);
  assign acc        = sum_q + SUM_W'(cnt);
  assign found      = acc > SUM_W'(pos_q);

  assign k_c  = {eff_r, 1'b1};
  assign kk_c = POS_W'(k_c) * POS_W'(k_c);

  assign ox_last  = $signed({1'b0, ox_q}) == lim_q;
  assign oy       = in_row_q - ROW_W'(eff_r);
  assign eof_c    = (oy == h_m1) && (ox_q == w_m1);
  assign job_last = (ky_q == two_r) && (j_q == jlast_q);

  shmf_ram #(
    .WIDTH(PIX_W),
    .DEPTH(RING * MAX_WIDTH)
  ) u_line_ram (
    .clk_i  (clk_i),
    .we_i   (line_we),
    .waddr_i(lw_addr),
    .wdata_i(pix_q),
    .re_i   (cmd_i.rd_line),
    .raddr_i(lr_addr),
    .rdata_o(line_rdata)
  );

  shmf_ram #(
    .WIDTH(CNT_W),
    .DEPTH(BINS)
  ) u_hist_ram (
    .clk_i  (clk_i),
    .we_i   (cmd_i.wr_hist),
    .waddr_i(v_q),
    .wdata_i(hist_wdata),
    .re_i   (cmd_i.rd_hist || cmd_i.scan),
    .raddr_i(hist_raddr),
    .rdata_o(hist_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q    <= W_RST;
      height_q   <= H_RST;
      radius_q   <= R_RST;
      in_col_q   <= '0;
      in_row_q   <= '0;
      in_slot_q  <= '0;
      out_col_q  <= '0;
      ox_q       <= '0;
      lim_q      <= '0;
      had_out_q  <= 1'b0;
      j_q        <= '0;
      ky_q       <= '0;
      jlast_q    <= '0;
      rebuild_q  <= 1'b0;
      sub_q      <= 1'b0;
      hist_vld_q <= '0;
      hv_q       <= 1'b0;
      scan_idx_q <= '0;
      rd_vld_q   <= 1'b0;
      done_q     <= 1'b0;
      sum_q      <= '0;
      out_vld_q  <= 1'b0;
    end else begin
      hv_q <= hist_vld_q[hist_raddr];
      if (cfg_we) begin
        unique case (cfg_index_i)
          REG_WIDTH:  width_q  <= cfg_data_i;
          REG_HEIGHT: height_q <= cfg_data_i;
          REG_RADIUS: radius_q <= cfg_data_i[2:0];
          default: ;
        endcase
      end
      if (cfg_hit) begin
        in_col_q  <= '0;
        in_row_q  <= '0;
        in_slot_q <= '0;
        out_col_q <= '0;
      end
      if (cmd_i.eval) begin
        ox_q      <= out_col_q;
        lim_q     <= lim_c;
        had_out_q <= has_out;
      end
      if (cmd_i.prep) begin
        j_q        <= '0;
        ky_q       <= '0;
        rebuild_q  <= (ox_q == '0);
        jlast_q    <= (ox_q == '0) ? two_r : SLOT_W'(1);
        scan_idx_q <= '0;
        rd_vld_q   <= 1'b0;
        done_q     <= 1'b0;
        sum_q      <= '0;
        if (ox_q == '0) begin
          hist_vld_q <= '0;
        end
      end
      if (cmd_i.addr) begin
        sub_q <= !rebuild_q && (j_q == '0);
      end
      if (cmd_i.wr_hist) begin
        hist_vld_q[v_q] <= 1'b1;
        if (ky_q == two_r) begin
          ky_q <= '0;
          j_q  <= j_q + SLOT_W'(1);
        end else begin
          ky_q <= ky_q + SLOT_W'(1);
        end
      end
      if (cmd_i.scan && !done_q) begin
        if (!scan_idx_q[BIN_AW]) begin
          scan_idx_q <= scan_idx_q + (BIN_AW + 1)'(1);
          rd_vld_q   <= 1'b1;
        end else begin
          rd_vld_q <= 1'b0;
        end
        if (rd_vld_q) begin
          sum_q <= acc;
          if (found || (data_idx_q == BIN_LAST)) begin
            done_q <= 1'b1;
          end
        end
      end
      if (cmd_i.emit && !ox_last) begin
        ox_q <= ox_q + WW'(1);
      end
      if (cmd_i.adv) begin
        if (in_col_q == w_m1) begin
          in_col_q  <= '0;
          out_col_q <= '0;
          if (in_row_q + ROW_W'(1) >= eff_h + ROW_W'(eff_r)) begin
            in_row_q  <= '0;
            in_slot_q <= '0;
          end else begin
            in_row_q  <= in_row_q + ROW_W'(1);
            in_slot_q <= (in_slot_q == SLOT_W'(RING - 1)) ? '0 : in_slot_q + SLOT_W'(1);
          end
        end else begin
          in_col_q <= in_col_q + WW'(1);
          if (had_out_q) begin
            out_col_q <= lim_q[WW-1:0] + WW'(1);
          end
        end
      end
      if (cmd_i.emit) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      op_q  <= op_i;
      pix_q <= pixel_i;
    end
    if (cmd_i.prep) begin
      pos_q <= kk_c >> 1;
    end
    if (cmd_i.addr) begin
      col_q  <= col_d;
      slot_q <= slot_d;
    end
    if (cmd_i.rd_hist) begin
      v_q <= line_rdata;
    end
    if (cmd_i.scan && !done_q) begin
      data_idx_q <= scan_idx_q[BIN_AW-1:0];
      if (rd_vld_q) begin
        med_q <= found ? data_idx_q : MED_NONE;
      end
    end
    if (cmd_i.emit) begin
      median_q <= med_q;
      last_q   <= ox_last;
      eof_q    <= eof_c;
    end
  end

  assign sts_o.kind_ok   = kind_ok;
  assign sts_o.has_out   = has_out;
  assign sts_o.job_last  = job_last;
  assign sts_o.scan_done = done_q;
  assign sts_o.ox_last   = ox_last;
  assign sts_o.out_free  = !out_vld_q || !out_stall_i;

  assign out_valid_o    = out_vld_q;
  assign median_o       = median_q;
  assign last_of_run_o  = last_q;
  assign end_of_frame_o = eof_q;

endmodule

// ----- rtl/core/sliding_histogram_median_filter_core.sv -----
// Top level of the sliding histogram median filter
//
//  port group | direction | handshake             | payload
//  -----------+-----------+-----------------------+---------------------------------------
//  in         | sink      | in_valid_i/in_stall_o | op_i, pixel_i
//  out        | source    | out_valid_o/out_stall_i | median_o, last_of_run_o, end_of_frame_o
//  cfg        | sink      | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
//  One item at a time: taken in idle, classified and stored in eval, moved on in adv.
//  Per result: prep, then addr, line read, histogram read and write for 2r+1 rows of U
//  columns (2r+1 at column 0, else 2), then a histogram scan up to the median bin.
//  Both RAMs have one write and one read port; reset leaves the line store undefined
//  and clears histogram valid bits. A stalled result holds while the next is computed.
`timescale 1ns / 1ps
module sliding_histogram_median_filter_core #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_RADIUS = 7
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        op_i,
  input  logic [shmf_pkg::PIX_W-1:0]  pixel_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [shmf_pkg::PIX_W-1:0]  median_o,
  output logic                        last_of_run_o,
  output logic                        end_of_frame_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [shmf_pkg::CFG_IW-1:0] cfg_index_i,
  input  logic [shmf_pkg::CFG_DW-1:0] cfg_data_i
);
  import shmf_pkg::*;

  shmf_cmd_t cmd;
  shmf_sts_t sts;

  shmf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .cfg_ready_o(cfg_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  shmf_datapath #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_RADIUS(MAX_RADIUS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .op_i          (op_i),
    .pixel_i       (pixel_i),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .out_stall_i   (out_stall_i),
    .out_valid_o   (out_valid_o),
    .median_o      (median_o),
    .last_of_run_o (last_of_run_o),
    .end_of_frame_o(end_of_frame_o)
  );

endmodule

// ----- rtl/core/shmf_checker.sv -----
// Port-level checks of the median filter and their bind
`timescale 1ns / 1ps
`include "sliding_histogram_median_filter_core_macros.svh"
module shmf_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [7:0]  median_o,
  input logic        last_of_run_o,
  input logic        end_of_frame_o,
  input logic        cfg_ready_o
);

  logic [9:0] res_bits;

  assign res_bits = {median_o, last_of_run_o, end_of_frame_o};

  // stalled result holds
  `SHMF_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i |=> out_valid_o && $stable(res_bits))
  // one item in flight: a transfer closes the input
  `SHMF_ASSERT(a_one_item, clk_i, rst_ni, in_valid_i && !in_stall_o |=> in_stall_o)
  // configuration only taken while input side is open
  `SHMF_ASSERT(a_cfg_idle, clk_i, rst_ni, cfg_ready_o == !in_stall_o)
  // frame end falls on a row end
  `SHMF_ASSERT_NEVER(a_eof_last, clk_i, rst_ni, out_valid_o && end_of_frame_o && !last_of_run_o)

endmodule

bind sliding_histogram_median_filter_core shmf_checker u_shmf_checker (.*);
